[design/mcec_pkg.sv]
// Package for the Markov context emission counter.
// Holds the sizing constants, opcode and register codes, and the queue command type.
// No dependencies; every other file of the block imports it.
package mcec_pkg;

    localparam int MAX_ORDER   = 5;
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_LABELS  = 32;

    localparam int HIST_W      = 2 * MAX_ORDER;
    localparam int TABLE_BITS  = HIST_W + 2;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int FILL_W      = $clog2(MAX_ORDER + 1);

    localparam int QUEUE_DEPTH = 4;

    localparam int NUC_W       = 2;
    localparam int LABEL_W     = 5;
    localparam int READ_IDX_W  = 12;
    localparam int OUT_W       = 32;
    localparam int ORDER_W     = 3;
    localparam int MASK_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int WIDE_W      = COUNT_WIDTH + OUT_W;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(5);

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_MASK   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CONTEXT_ORDER = CFG_INDEX_W'(1);

    typedef struct packed {
        logic                  is_read;
        logic [TABLE_BITS-1:0] addr;
    } cmd_t;

    // Counters wider than the output port are clipped to its top value.
    function automatic logic [OUT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] v);
        logic [OUT_W-1:0] r;
        if (WIDE_W'(v) > WIDE_W'({OUT_W{1'b1}}))
        begin
            r = '1;
        end
        else
        begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage

[design/mcec_in_if.sv]
// Input channel of the Markov context emission counter: valid/ready plus one position.
// Depends on mcec_pkg for the field widths.
interface mcec_in_if;
    import mcec_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [NUC_W-1:0]      nucleotide;
    logic [LABEL_W-1:0]    state_label;
    logic                  range_start;
    logic [READ_IDX_W-1:0] read_index;

    modport source (output valid, opcode, nucleotide, state_label, range_start, read_index,
                    input ready);
    modport sink   (input valid, opcode, nucleotide, state_label, range_start, read_index,
                    output ready);
endinterface

[design/mcec_out_if.sv]
// Output channel of the Markov context emission counter: valid/ready plus one count.
// Depends on mcec_pkg for the field width.
interface mcec_out_if;
    import mcec_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] count_value;

    modport source (output valid, count_value, input ready);
    modport sink   (input valid, count_value, output ready);
endinterface

[design/mcec_front.sv]
// Front end: configuration registers, base history and classification of each position.
// Depends on mcec_pkg and mcec_in_if; feeds commands to mcec_queue.
module mcec_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mcec_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mcec_pkg::CFG_DATA_W-1:0]  cfg_data,
    mcec_in_if.sink                          in_ch,
    input  logic                             hold,
    output logic                             push_valid,
    output mcec_pkg::cmd_t                   push_cmd,
    input  logic                             push_ready
);
    import mcec_pkg::*;

    logic [MASK_W-1:0]  mask_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [HIST_W-1:0]  hist_reg, hist_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    logic [ORDER_W-1:0] k;
    logic [HIST_W-1:0]  hist_base;
    logic [FILL_W-1:0]  fill_base;
    logic [HIST_W-1:0]  ctx_mask;
    logic               label_on;
    logic               count_ok;
    logic               is_read;
    logic               fire;

    assign in_ch.ready = push_ready && !hold;
    assign fire        = in_ch.valid && in_ch.ready;
    assign is_read     = (in_ch.opcode == OP_READ);

    always_comb
    begin
        if (order_reg == '0)
        begin
            k = ORDER_W'(1);
        end
        else if (order_reg > ORDER_W'(MAX_ORDER))
        begin
            k = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            k = order_reg;
        end

        // A range start wipes the history before this position is looked at.
        hist_base = in_ch.range_start ? '0 : hist_reg;
        fill_base = in_ch.range_start ? '0 : fill_reg;

        for (int i = 0; i < MAX_ORDER; i++)
        begin
            ctx_mask[2*i +: 2] = (i < int'(k)) ? 2'b11 : 2'b00;
        end

        label_on = (int'(in_ch.state_label) < NUM_LABELS) && mask_reg[in_ch.state_label];
        count_ok = (int'(fill_base) >= int'(k)) && label_on;

        push_cmd.is_read = is_read;
        push_cmd.addr    = is_read ? TABLE_BITS'(in_ch.read_index)
                                   : {hist_base & ctx_mask, in_ch.nucleotide};
        push_valid       = fire && (is_read || count_ok);

        hist_next = hist_reg;
        fill_next = fill_reg;
        if (fire && !is_read)
        begin
            hist_next = HIST_W'({hist_base, in_ch.nucleotide});
            fill_next = (int'(fill_base) < MAX_ORDER) ? fill_base + 1'b1 : fill_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            order_reg <= ORDER_RESET;
            hist_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            fill_reg <= fill_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARGET_MASK:   mask_reg  <= cfg_data[MASK_W-1:0];
                    REG_CONTEXT_ORDER: order_reg <= cfg_data[ORDER_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

[design/mcec_queue.sv]
// Short command queue between the front end and the table engine.
// Depends on mcec_pkg for cmd_t and QUEUE_DEPTH.
module mcec_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mcec_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mcec_pkg::cmd_t pop_cmd
);
    import mcec_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_fire && !push_fire) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not follow a pop");
`endif

endmodule

[design/mcec_back.sv]
// Back end: the count table memory, its clearing pass and the read-modify-write engine.
// Depends on mcec_pkg and mcec_out_if; takes commands from mcec_queue.
module mcec_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  mcec_pkg::cmd_t pop_cmd,
    output logic           clear_busy,
    mcec_out_if.source     out_ch
);
    import mcec_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_FETCH, S_ACCESS} state_t;

    logic [COUNT_WIDTH-1:0] table_mem [TABLE_SIZE];

    state_t                 state_reg;
    logic [TABLE_BITS-1:0]  clr_reg;
    cmd_t                   cmd_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic [COUNT_WIDTH-1:0] rdata_reg;

    logic                   mem_we;
    logic [TABLE_BITS-1:0]  mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [TABLE_BITS-1:0]  rd_addr;
    logic                   out_free;
    logic                   out_load;

    assign clear_busy     = (state_reg == S_CLEAR);
    assign pop_ready      = (state_reg == S_FETCH);
    assign out_free       = !out_valid_reg || out_ch.ready;
    assign out_load       = (state_reg == S_ACCESS) && cmd_reg.is_read && out_free;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.count_value = out_data_reg;

    always_comb
    begin
        rd_addr   = (state_reg == S_FETCH) ? pop_cmd.addr : cmd_reg.addr;
        mem_we    = 1'b0;
        mem_waddr = cmd_reg.addr;
        // The counter sticks at its top value.
        mem_wdata = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_ACCESS && !cmd_reg.is_read)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= clip_count(rdata_reg);
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    if (pop_valid)
                    begin
                        cmd_reg   <= pop_cmd;
                        state_reg <= S_ACCESS;
                    end
                end
                S_ACCESS:
                begin
                    if (!cmd_reg.is_read || out_free)
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= S_FETCH;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_clear_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_busy) |-> clr_reg == '0)
        else $error("clearing pass ended before sweeping the whole table");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ACCESS && cmd_reg.is_read))
        else $error("result raised without a read command");

    a_count_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCESS && !cmd_reg.is_read) |=> state_reg == S_FETCH)
        else $error("count update did not finish in one access cycle");
`endif

endmodule

[design/markov_context_emission_counter_top.sv]
// Top level of the Markov context emission counter.
// Depends on mcec_pkg, mcec_in_if, mcec_out_if, mcec_front, mcec_queue and mcec_back.
//
// Usage:
// Positions arrive on in_ch as valid/ready transfers. A count position (opcode 0) updates
// the base history and, when enough bases of the current range are known and its label is
// enabled in target_mask, bumps one saturating counter of the 4096-entry table. A read
// (opcode 1) returns the counter at read_index as one transfer on out_ch; counts return
// nothing. Configuration goes through cfg_we/cfg_index/cfg_data while the block is idle:
// index 0 is target_mask, index 1 is context_order.
// After reset the table is swept to zero, one entry per cycle; in_ch.ready stays low
// during that pass while configuration writes are still taken. The front end takes one
// position per cycle, while the queue has room, into a four-entry command queue. The
// table engine handles each queued command in S_FETCH (one memory read) and then S_ACCESS
// (the write-back or the result load) and takes a new command only after finishing the
// last one, while positions that are not counted never reach the queue. When the queue is
// empty, a read's result still passes through the queue slot, the engine's command and
// read-data registers and the output register before out_ch.valid rises. If the receiver
// stalls, the result waits in the output register; the engine stops only when the next
// read needs that register, and the front end keeps taking items until the queue fills.
module markov_context_emission_counter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mcec_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mcec_pkg::CFG_DATA_W-1:0]  cfg_data,
    mcec_in_if.sink                          in_ch,
    mcec_out_if.source                       out_ch
);
    import mcec_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;
    logic clear_busy;

    // Classification and history; stalls only on a full queue or during the clearing pass.
    mcec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .hold       (clear_busy),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Decouples the front end, which takes one position per cycle unless held, from the table engine.
    mcec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Commands are executed strictly in order, so a read always sees every earlier count.
    mcec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .clear_busy (clear_busy),
        .out_ch     (out_ch)
    );

endmodule

[dv/mcec_tally_checker.sv]
// Checker for the Markov context emission counter: watches the configuration port and both channels.
// Keeps its own copy of the count table and history and compares every result transfer.
// Depends on mcec_pkg, mcec_in_if and mcec_out_if.
`timescale 1ns / 100ps

module mcec_tally_checker
    import mcec_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mcec_in_if                     in_mon,
    mcec_out_if                    out_mon,
    output int                     error_count,
    output int                     pending_reads
);

    localparam int REPORT_LIMIT = 10;

    logic [COUNT_WIDTH-1:0] tally [TABLE_SIZE];
    logic [HIST_W-1:0]      recent_bases;
    int unsigned            bases_seen;
    logic [MASK_W-1:0]      label_enable;
    logic [ORDER_W-1:0]     order_setting;
    logic [OUT_W-1:0]       expected_counts [$];
    logic [OUT_W-1:0]       wanted;

    // Order 0 behaves as 1 and anything past the deepest context is clamped.
    function automatic int unsigned context_depth(input logic [ORDER_W-1:0] setting);
        int unsigned depth;
        depth = setting;
        if (depth < 1)
        begin
            depth = 1;
        end
        if (depth > MAX_ORDER)
        begin
            depth = MAX_ORDER;
        end
        return depth;
    endfunction

    function automatic logic [OUT_W-1:0] clip_to_port(input logic [COUNT_WIDTH-1:0] v);
        if (64'(v) > 64'({OUT_W{1'b1}}))
        begin
            return '1;
        end
        return OUT_W'(v);
    endfunction

    task automatic count_position(input logic [NUC_W-1:0] nuc, input logic [LABEL_W-1:0] label,
                                  input logic start);
        int unsigned           depth;
        logic [HIST_W-1:0]     ctx;
        logic [TABLE_BITS-1:0] slot;
        if (start)
        begin
            recent_bases = '0;
            bases_seen   = 0;
        end
        depth = context_depth(order_setting);
        if (bases_seen >= depth && int'(label) < NUM_LABELS && int'(label) < MASK_W
            && label_enable[label])
        begin
            ctx  = HIST_W'(32'(recent_bases) & ((32'd1 << (2 * depth)) - 32'd1));
            slot = TABLE_BITS'({ctx, nuc});
            if (tally[slot] != '1)
            begin
                tally[slot] = tally[slot] + 1'b1;
            end
        end
        recent_bases = HIST_W'({recent_bases, nuc});
        if (bases_seen < MAX_ORDER)
        begin
            bases_seen++;
        end
    endtask

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("[%0t] checker: %s", $realtime, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < TABLE_SIZE; e++)
            begin
                tally[e] = '0;
            end
            recent_bases  = '0;
            bases_seen    = 0;
            label_enable  = '0;
            order_setting = ORDER_RESET;
            expected_counts.delete();
            error_count   = 0;
            pending_reads = 0;
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                if (cfg_index == REG_TARGET_MASK)
                begin
                    label_enable = MASK_W'(cfg_data);
                end
                else if (cfg_index == REG_CONTEXT_ORDER)
                begin
                    order_setting = ORDER_W'(cfg_data);
                end
            end
            if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
            begin
                if (in_mon.opcode == OP_READ)
                begin
                    expected_counts.push_back(
                        clip_to_port(tally[TABLE_BITS'(in_mon.read_index)]));
                end
                else
                begin
                    count_position(in_mon.nucleotide, in_mon.state_label, in_mon.range_start);
                end
            end
            if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
            begin
                if (expected_counts.size() == 0)
                begin
                    note_error($sformatf("result transfer 0x%08h with no read waiting for it",
                                         out_mon.count_value));
                end
                else
                begin
                    wanted = expected_counts.pop_front();
                    if (out_mon.count_value !== wanted)
                    begin
                        note_error($sformatf("count_value expected %0d (0x%08h), got %0d (0x%08h)",
                                             wanted, wanted, out_mon.count_value,
                                             out_mon.count_value));
                    end
                end
            end
            pending_reads = expected_counts.size();
        end
    end

endmodule

[dv/markov_context_emission_counter_top_test.sv]
// Testbench top for the Markov context emission counter: clock, reset, stimulus and verdict.
// Drives directed and random positions through the channels; mcec_tally_checker does the checking.
// Depends on mcec_pkg, mcec_in_if, mcec_out_if, mcec_tally_checker and the block's top level.
`timescale 1ns / 100ps

module markov_context_emission_counter_top_test;
    import mcec_pkg::*;

    // Cycles to let the command queue drain after the last result before touching registers.
    // Four queued counts plus the pipeline fit well inside this.
    localparam int SETTLE_CYCLES = 16;
    // Upper bound on the wait for outstanding results at the end of the run.
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic                  opcode;
        logic [NUC_W-1:0]      nucleotide;
        logic [LABEL_W-1:0]    state_label;
        logic                  range_start;
        logic [READ_IDX_W-1:0] read_index;
    } position_t;

    // Receiver behavior, picked anew at random for each stretch of the run.
    typedef enum int {RX_OPEN, RX_COIN, RX_BLOCKS} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int error_count;
    int pending_reads;

    mcec_in_if  in_ch ();
    mcec_out_if out_ch ();

    markov_context_emission_counter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    mcec_tally_checker tally_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .error_count   (error_count),
        .pending_reads (pending_reads)
    );

    always #6 clk = ~clk;

    // Sender state. The burst counter says how many more transfers go out back to back
    // before the next gap; gap_max bounds most gaps of the current phase, with a rare longer
    // gap beyond it, and zero gives a stretch with no idling at all.
    int burst_left;
    int gap_max;

    // The stimulus keeps its own view of the bases it has sent so that reads can be aimed
    // at counters that are actually being bumped. With a deep context and random bases,
    // a uniformly random read address would almost always land on a zero counter.
    logic [HIST_W-1:0]     sent_bases;
    int                    sent_fill;
    logic [ORDER_W-1:0]    sent_order;
    logic [TABLE_BITS-1:0] hot_addrs [$];

    function automatic int depth_of(input logic [ORDER_W-1:0] setting);
        int depth;
        depth = setting;
        if (depth < 1)
        begin
            depth = 1;
        end
        if (depth > MAX_ORDER)
        begin
            depth = MAX_ORDER;
        end
        return depth;
    endfunction

    function automatic position_t make_position(input logic op, input int nuc, input int label,
                                                input logic start, input int index);
        position_t p;
        p.opcode      = op;
        p.nucleotide  = NUC_W'(nuc);
        p.state_label = LABEL_W'(label);
        p.range_start = start;
        p.read_index  = READ_IDX_W'(index);
        return p;
    endfunction

    // A random position. Reads mostly target addresses that recent counts went to; the rest
    // of the time, and for the nucleotide and label fields that a read ignores, the bits are fully random.
    function automatic position_t random_position(input int read_pct, input int restart_pct);
        position_t p;
        p.opcode      = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_COUNT;
        p.nucleotide  = NUC_W'($urandom);
        p.state_label = LABEL_W'($urandom);
        p.range_start = ($urandom_range(0, 99) < restart_pct);
        p.read_index  = READ_IDX_W'($urandom);
        if (p.opcode == OP_READ && hot_addrs.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            p.read_index = READ_IDX_W'(hot_addrs[$urandom_range(0, hot_addrs.size() - 1)]);
        end
        return p;
    endfunction

    // Drives one position and holds it until the block takes it. Called at a falling edge
    // and returns at a falling edge. valid is only lowered when a gap actually follows, so
    // back-to-back transfers never see valid dropped and raised in the same time step.
    task automatic send_position(input position_t p);
        int gap;
        int depth;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if ($urandom_range(0, 15) == 0 && gap_max > 0)
            begin
                gap = $urandom_range(10, 30);
            end
            if (gap > 0)
            begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.opcode      = p.opcode;
        in_ch.nucleotide  = p.nucleotide;
        in_ch.state_label = p.state_label;
        in_ch.range_start = p.range_start;
        in_ch.read_index  = p.read_index;
        in_ch.valid       = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        @(negedge clk);
        burst_left--;

        if (p.opcode == OP_COUNT)
        begin
            if (p.range_start)
            begin
                sent_bases = '0;
                sent_fill  = 0;
            end
            depth = depth_of(sent_order);
            if (sent_fill >= depth)
            begin
                hot_addrs.push_back(TABLE_BITS'({HIST_W'(32'(sent_bases)
                                                 & ((32'd1 << (2 * depth)) - 32'd1)),
                                                 p.nucleotide}));
                if (hot_addrs.size() > 32)
                begin
                    void'(hot_addrs.pop_front());
                end
            end
            sent_bases = HIST_W'({sent_bases, p.nucleotide});
            if (sent_fill < MAX_ORDER)
            begin
                sent_fill++;
            end
        end
    endtask

    // Stops sending and waits for every read result, which is also the pause the
    // pressure test asks for.
    task automatic hold_until_empty();
        in_ch.valid = 1'b0;
        burst_left  = 0;
        while (pending_reads != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Registers change only with the block idle. Counts give no result, so after the last
    // read has come back the queue may still hold counts; the settle time covers them.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (index == REG_CONTEXT_ORDER)
        begin
            sent_order = ORDER_W'(data);
        end
    endtask

    // The order field is only three bits wide; the bits above it are filled with noise.
    task automatic write_order(input logic [ORDER_W-1:0] order);
        write_reg(REG_CONTEXT_ORDER, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'({ORDER_W{1'b1}}))
                                     | CFG_DATA_W'(order));
    endtask

    task automatic run_phase(input logic [MASK_W-1:0] mask, input logic [ORDER_W-1:0] order,
                             input int items, input int read_pct, input int restart_pct,
                             input int gaps);
        write_reg(REG_TARGET_MASK, CFG_DATA_W'(mask));
        write_order(order);
        gap_max = gaps;
        for (int n = 0; n < items; n++)
        begin
            // Halfway through, the sender waits for all outstanding results once.
            if (n == items / 2)
            begin
                hold_until_empty();
            end
            send_position(random_position(read_pct, restart_pct));
        end
    endtask

    // Receiver: switches between always ready, a coin toss per cycle, and mostly ready with
    // occasional long stalls, so stalls land on every stage of the result path.
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       stall_left;
        out_ch.ready = 1'b0;
        rx_mode      = RX_OPEN;
        mode_left    = 0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:
                begin
                    out_ch.ready = 1'b1;
                end
                RX_COIN:
                begin
                    out_ch.ready = 1'($urandom_range(0, 1));
                end
                default:
                begin
                    if (stall_left > 0)
                    begin
                        out_ch.ready = 1'b0;
                        stall_left--;
                    end
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        out_ch.ready = 1'b0;
                        stall_left   = $urandom_range(5, 40);
                    end
                    else
                    begin
                        out_ch.ready = 1'b1;
                    end
                end
            endcase
        end
    end

    // Main stimulus: reset, a directed pass over the special cases, random phases, then
    // the drain and the verdict.
    initial
    begin
        int drained;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_COUNT;
        in_ch.nucleotide  = '0;
        in_ch.state_label = '0;
        in_ch.range_start = 1'b0;
        in_ch.read_index  = '0;
        burst_left        = 0;
        gap_max           = 3;
        sent_bases        = '0;
        sent_fill         = 0;
        sent_order        = ORDER_RESET;

        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Reset values: the mask is clear, so nothing counts. The stream also starts
        // without any range start, which must act as if a range began at reset.
        send_position(make_position(OP_COUNT, 3, 0, 1'b0, 12'hFFF));
        send_position(make_position(OP_COUNT, 0, 31, 1'b0, 0));
        send_position(make_position(OP_COUNT, 2, 16, 1'b0, 12'hABC));
        send_position(make_position(OP_READ, 0, 0, 1'b0, 0));
        send_position(make_position(OP_READ, 3, 31, 1'b1, 12'hFFF));

        // Order 1, every label enabled. Contexts 2,1,3,0 give counters 9, 7, 12 and 3.
        write_reg(REG_TARGET_MASK, CFG_DATA_W'(32'hFFFF_FFFF));
        write_order(ORDER_W'(1));
        send_position(make_position(OP_COUNT, 2, 31, 1'b1, 12'hFFF));
        send_position(make_position(OP_COUNT, 1, 0, 1'b0, 0));
        send_position(make_position(OP_COUNT, 3, 17, 1'b0, 12'h555));
        send_position(make_position(OP_COUNT, 0, 31, 1'b0, 12'hAAA));
        send_position(make_position(OP_COUNT, 3, 5, 1'b0, 0));
        // A read carrying a range start must not disturb the history.
        send_position(make_position(OP_READ, 3, 31, 1'b1, 9));
        send_position(make_position(OP_READ, 0, 0, 1'b0, 7));
        send_position(make_position(OP_COUNT, 2, 8, 1'b0, 0));
        send_position(make_position(OP_READ, 2, 12, 1'b1, 14));
        send_position(make_position(OP_READ, 1, 3, 1'b0, 12));
        // Never written at this order, so it reads zero.
        send_position(make_position(OP_READ, 0, 0, 1'b0, 12'hFFF));

        // An order of zero behaves as one; only label 0 is enabled now.
        write_reg(REG_TARGET_MASK, CFG_DATA_W'(32'h0000_0001));
        write_order(ORDER_W'(0));
        send_position(make_position(OP_COUNT, 1, 1, 1'b0, 0));
        send_position(make_position(OP_COUNT, 1, 0, 1'b0, 0));
        send_position(make_position(OP_READ, 0, 0, 1'b0, 9));
        send_position(make_position(OP_READ, 0, 0, 1'b0, 5));

        // An order above the deepest context clamps to it; only label 31 is enabled.
        // Six equal bases after a range start bump the very top counter once.
        write_reg(REG_TARGET_MASK, CFG_DATA_W'(32'h8000_0000));
        write_order(ORDER_W'(7));
        send_position(make_position(OP_COUNT, 3, 31, 1'b1, 0));
        repeat (5) send_position(make_position(OP_COUNT, 3, 31, 1'b0, 0));
        send_position(make_position(OP_COUNT, 3, 30, 1'b0, 0));
        send_position(make_position(OP_READ, 0, 0, 1'b0, 12'hFFF));

        // Random phases. History carries over between them, so each order change happens
        // in the middle of a range. One phase restarts ranges so often that the history
        // rarely fills, and one runs with the mask cleared.
        run_phase(32'hFFFF_FFFF, ORDER_W'(1), 120, 35, 5, 6);
        run_phase(MASK_W'($urandom), ORDER_W'(5), 130, 30, 2, 0);
        run_phase(32'hFFFF_FFFF, ORDER_W'(5), 130, 30, 3, 4);
        run_phase(32'h0000_0000, ORDER_W'(3), 60, 30, 5, 6);
        run_phase(MASK_W'($urandom), ORDER_W'(2), 110, 30, 40, 3);
        run_phase(32'hAAAA_AAAA, ORDER_W'(4), 120, 30, 4, 8);
        run_phase(32'h5555_5555, ORDER_W'(6), 120, 30, 4, 2);
        run_phase(32'hFFFF_FFFF, ORDER_W'(0), 110, 35, 10, 5);

        // Drain: wait for the last results, bounded, then give the queue time to settle.
        in_ch.valid = 1'b0;
        drained = 0;
        while (pending_reads != 0 && drained < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drained++;
        end
        if (pending_reads != 0)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (error_count == 0)
            begin
                $display("DONE: 0 errors");
            end
            else
            begin
                $display("DONE: errors detected");
            end
            $finish;
        end
    end

    // Watchdog: far beyond the slowest correct run, including the table clear after reset.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
design/mcec_pkg.sv
design/mcec_in_if.sv
design/mcec_out_if.sv
design/mcec_front.sv
design/mcec_queue.sv
design/mcec_back.sv
design/markov_context_emission_counter_top.sv
dv/mcec_tally_checker.sv
dv/markov_context_emission_counter_top_test.sv
